@@ hw/rtl/steq_pkg.sv @@
package steq_pkg;

  // Input action codes.
  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // What the cell row does at the next edge.
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_POP   = 2'd2
  } cell_op_t;

  // One queued event: time plus payload.
  typedef struct packed {
    logic [31:0] ev_time;
    logic [3:0]  kind;
    logic [7:0]  source;
    logic [7:0]  dest;
    logic [7:0]  hops;
    logic [15:0] path_ref;
  } entry_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    cell_op_t op;
    entry_t   ent;
  } cell_cmd_t;

endpackage

@@ hw/rtl/steq_if.sv @@
interface steq_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] event_time;
  logic [3:0]  event_kind;
  logic [7:0]  source_node;
  logic [7:0]  dest_node;
  logic [7:0]  hop_count;
  logic [15:0] path_ref;

  modport source (
    output valid, action, event_time, event_kind, source_node, dest_node,
           hop_count, path_ref,
    input  ready
  );
  modport sink (
    input  valid, action, event_time, event_kind, source_node, dest_node,
           hop_count, path_ref,
    output ready
  );
endinterface

interface steq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] out_time;
  logic [3:0]  out_kind;
  logic [7:0]  out_source;
  logic [7:0]  out_dest;
  logic [7:0]  out_hops;
  logic [15:0] out_path_ref;
  logic        now_empty;
  logic [6:0]  occupancy;

  modport source (
    output valid, status, out_time, out_kind, out_source, out_dest, out_hops,
           out_path_ref, now_empty, occupancy,
    input  ready
  );
  modport sink (
    input  valid, status, out_time, out_kind, out_source, out_dest, out_hops,
           out_path_ref, now_empty, occupancy,
    output ready
  );
endinterface

@@ hw/rtl/steq_cell.sv @@
module steq_cell (
  input  logic               clk,
  input  steq_pkg::cell_cmd_t cmd,
  input  logic               is_valid,
  input  logic               prev_keep,
  input  steq_pkg::entry_t   prev_ent,
  input  steq_pkg::entry_t   next_ent,
  output logic               keep,
  output steq_pkg::entry_t   ent
);
  import steq_pkg::*;

  entry_t ent_next;

  // A valid cell whose time is not later than the new one stays in place.
  assign keep = is_valid && (ent.ev_time <= cmd.ent.ev_time);

  always_comb begin
    ent_next = ent;
    case (cmd.op)
      OP_PUSH: begin
        if (!keep) begin
          // The first cell that does not keep takes the new event; the
          // cells behind it move one place back.
          ent_next = prev_keep ? cmd.ent : prev_ent;
        end
      end
      OP_POP:  ent_next = next_ent;
      default: ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

@@ hw/rtl/stable_time_ordered_event_queue.sv @@
// Time-ordered event queue for a discrete-event scheduler. Each input beat
// is a push (insert an event in ascending time order, behind any queued
// events with the same time) or a pop (remove the earliest event). Every
// input beat yields exactly one result beat with status, the popped event
// (zero unless a pop succeeded), an empty flag and the occupancy after the
// step. A push to a full queue is dropped with status 2; a pop from an empty
// queue reports status 1. Storage is a row of CAPACITY cells kept sorted,
// slot 0 holding the earliest event. One beat is taken per clock cycle while
// the output register is free or drains; its result is registered in the
// following cycle. Each new time is compared combinationally against every
// cell, the row shifts one place, and no clearing pass is needed after reset.
module stable_time_ordered_event_queue #(
  parameter int CAPACITY = 64
) (
  input  logic clk,
  input  logic rst,
  steq_in_if.sink    req,
  steq_out_if.source rsp
);
  import steq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Number of queued events; cell i is in use when i < count.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  cell_cmd_t cmd;
  entry_t    ents  [CAPACITY];
  logic      keeps [CAPACITY];

  logic    accept;
  logic    is_full;
  logic    is_empty;
  status_t status_next;
  entry_t  head_next;

  // Output register.
  logic    out_valid;
  status_t out_status;
  entry_t  out_ent;
  logic    out_empty;
  logic [6:0] out_occ;

  // The input is taken whenever the output register is free or drains now.
  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign is_full  = (count == CNT_W'(CAPACITY));
  assign is_empty = (count == '0);

  always_comb begin
    cmd.op              = OP_HOLD;
    cmd.ent.ev_time     = req.event_time;
    cmd.ent.kind        = req.event_kind;
    cmd.ent.source      = req.source_node;
    cmd.ent.dest        = req.dest_node;
    cmd.ent.hops        = req.hop_count;
    cmd.ent.path_ref    = req.path_ref;
    count_next          = count;
    status_next         = STAT_OK;
    head_next           = '0;
    case (action_t'(req.action))
      ACT_PUSH: begin
        if (is_full) begin
          status_next = STAT_FULL;
        end else begin
          if (accept) begin
            cmd.op = OP_PUSH;
          end
          count_next = count + CNT_W'(1);
        end
      end
      ACT_POP: begin
        if (is_empty) begin
          status_next = STAT_EMPTY;
        end else begin
          if (accept) begin
            cmd.op = OP_POP;
          end
          count_next = count - CNT_W'(1);
          head_next  = ents[0];
        end
      end
      default: status_next = STAT_OK;
    endcase
  end

  // The cell row. Each cell sees only its neighbors and the broadcast
  // command. The first cell treats the slot before it as kept, so that it takes
  // the new event when nothing precedes it; the last cell shifts in itself
  // on a pop, which is harmless since it then falls out of use.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   prev_keep;
    entry_t prev_ent;
    entry_t next_ent;
    logic   in_use;

    assign in_use = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign prev_keep = 1'b1;
      assign prev_ent  = cmd.ent;
    end else begin : g_mid
      assign prev_keep = keeps[i-1];
      assign prev_ent  = ents[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_ent = ents[i];
    end else begin : g_inner
      assign next_ent = ents[i+1];
    end

    steq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .is_valid  (in_use),
      .prev_keep (prev_keep),
      .prev_ent  (prev_ent),
      .next_ent  (next_ent),
      .keep      (keeps[i]),
      .ent       (ents[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status_next;
      out_ent    <= head_next;
      out_empty  <= (count_next == '0);
      out_occ    <= 7'(count_next);
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.out_time     = out_ent.ev_time;
  assign rsp.out_kind     = out_ent.kind;
  assign rsp.out_source   = out_ent.source;
  assign rsp.out_dest     = out_ent.dest;
  assign rsp.out_hops     = out_ent.hops;
  assign rsp.out_path_ref = out_ent.path_ref;
  assign rsp.now_empty    = out_empty;
  assign rsp.occupancy    = out_occ;

  // The queue never holds more events than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("queue count above capacity");

  // A successful pop removes exactly one event.
  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    accept && req.action == ACT_POP && !is_empty |=> count == $past(count) - CNT_W'(1))
    else $error("pop did not remove one event");

  // A push to a full queue leaves the count alone.
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    accept && req.action == ACT_PUSH && is_full |=> count == $past(count))
    else $error("dropped push changed the count");

  // A failed step returns no event.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != STAT_OK |-> out_ent == '0)
    else $error("error result carries an event");

endmodule
